### hdl/sitd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_pkg: shared types and constants of the stream deframer
// Result kinds, parser modes, record field offsets, the result bundle and
// the light percentage helper.
// ----------------------------------------------------------------------------
package sitd_pkg;

    localparam int RECORD_BYTES_DEF  = 36;
    localparam int LENGTH_DIGITS_DEF = 7;

    localparam logic [7:0] SYNC_RESET = 8'hBB;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Byte offsets inside a sensor record
    localparam int TEMP_POS  = 4;
    localparam int HUMI_POS  = 6;
    localparam int LIGHT_POS = 20;

    localparam logic [31:0] LIGHT_FULL    = 32'd1000;
    localparam logic [6:0]  PERCENT_FULL  = 7'd100;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    // x / 10 == (x * 205) >> 11 for every x up to 1000
    localparam logic [7:0]  RECIP_TEN     = 8'd205;
    localparam int          RECIP_SHIFT   = 11;

    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_LINE    = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_RECORD  = 5'b00010,
        MODE_DIGITS  = 5'b00100,
        MODE_PAYLOAD = 5'b01000,
        MODE_TEXT    = 5'b10000
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [31:0] light_level;
        logic [6:0]  light_percent;
        logic [23:0] image_length;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [15:0] line_length;
    } result_t;

    function automatic logic [6:0] light_to_percent(input logic [31:0] light);
        logic [17:0] prod;
        prod = {8'd0, light[9:0]} * {10'd0, RECIP_TEN};
        if (light > LIGHT_FULL)
            return PERCENT_FULL;
        return prod[RECIP_SHIFT +: 7];
    endfunction

endpackage
`default_nettype wire

### hdl/sensor_image_text_stream_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_image_text_stream_deframer_unit: byte stream deframer
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per
//   transfer. The res channel (res_valid/res_ready plus one port per field)
//   gives at most one result per byte: a finished sensor record, an image
//   length header, one image payload byte, or the length of a text line.
//   Fields that do not belong to the result kind read as zero. Results are
//   registered as their byte transfers. Throughput: one byte per cycle unless
//   stalled, set by the single parse-state register loop; bytes that cause no
//   result vanish silently. The result register parts the two sides: rx_ready
//   is high whenever the result register is empty or is being drained in the
//   same cycle, so a stalled receiver holds res_valid and the result steady
//   and back-pressures the byte input only while a result waits. Reset:
//   parser returns to idle with all captured fields and counters at zero, the
//   result register empties, and sync_byte returns to 0xBB. sync_byte is
//   written through sync_byte_we/sync_byte_wdata while idle; the user must
//   keep to that, as the block does not enforce it.
// ----------------------------------------------------------------------------
module sensor_image_text_stream_deframer_unit #(
    parameter int RECORD_BYTES  = sitd_pkg::RECORD_BYTES_DEF,
    parameter int LENGTH_DIGITS = sitd_pkg::LENGTH_DIGITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        sync_byte_we,
    input  wire logic [7:0]  sync_byte_wdata,
    // byte input
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    // results
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [1:0]       out_kind,
    output logic [15:0]      temperature,
    output logic [15:0]      humidity,
    output logic [31:0]      light_level,
    output logic [6:0]       light_percent,
    output logic [23:0]      image_length,
    output logic [7:0]       payload_byte,
    output logic             payload_last,
    output logic [15:0]      line_length
);

    logic [7:0]        sync_reg;
    logic              res_valid_reg, res_valid_next;
    sitd_pkg::result_t res_reg, res_next;
    sitd_pkg::result_t parse_res;
    logic              parse_fire;
    logic              rx_take;

    // Accept a byte whenever the result slot is free or drains this cycle
    assign rx_ready = !res_valid_reg || res_ready;
    assign rx_take  = rx_valid && rx_ready;

    sitd_parser #(
        .RECORD_BYTES  (RECORD_BYTES),
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (rx_take),
        .rx_byte   (rx_byte),
        .sync_byte (sync_reg),
        .res       (parse_res),
        .res_fire  (parse_fire)
    );

    // Result slot: load on a producing transfer, drop when taken, else hold
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (rx_ready)
        begin
            res_valid_next = rx_take && parse_fire;
            if (rx_take && parse_fire)
                res_next = parse_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sync_reg      <= sitd_pkg::SYNC_RESET;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (sync_byte_we)
                sync_reg <= sync_byte_wdata;
        end
    end

    // Payload register: no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid     = res_valid_reg;
    assign out_kind      = res_reg.kind;
    assign temperature   = res_reg.temperature;
    assign humidity      = res_reg.humidity;
    assign light_level   = res_reg.light_level;
    assign light_percent = res_reg.light_percent;
    assign image_length  = res_reg.image_length;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_last  = res_reg.payload_last;
    assign line_length   = res_reg.line_length;

endmodule
`default_nettype wire

### hdl/sitd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_parser: frame state and field capture
// Holds the parse state, updates it once per transferred byte and flags a
// result when that byte completes a record, header, payload byte or line.
// ----------------------------------------------------------------------------
module sitd_parser #(
    parameter int RECORD_BYTES  = sitd_pkg::RECORD_BYTES_DEF,
    parameter int LENGTH_DIGITS = sitd_pkg::LENGTH_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        sync_byte,
    output sitd_pkg::result_t      res,
    output logic                   res_fire
);

    localparam int IDX_W = $clog2(RECORD_BYTES);

    sitd_pkg::mode_t mode_reg, mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_inc;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] humi_reg, humi_next;
    logic [31:0] light_reg, light_next;
    logic [23:0] accum_reg, accum_next, accum_step;
    logic [23:0] remain_reg, remain_next, remain_dec;
    logic [15:0] text_reg, text_next, text_inc;
    logic        is_digit;
    logic [3:0]  digit_val;

    assign is_digit   = (rx_byte >= sitd_pkg::ASCII_ZERO) && (rx_byte <= sitd_pkg::ASCII_NINE);
    assign digit_val  = 4'(rx_byte - sitd_pkg::ASCII_ZERO);
    assign accum_step = (accum_reg << 3) + (accum_reg << 1) + {20'd0, digit_val};
    assign idx_inc    = idx_reg + 1'b1;
    assign text_inc   = (text_reg == sitd_pkg::COUNT_MAX) ? text_reg : text_reg + 16'd1;
    assign remain_dec = (remain_reg == 24'd0) ? 24'd0 : remain_reg - 24'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        temp_next   = temp_reg;
        humi_next   = humi_reg;
        light_next  = light_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        text_next   = text_reg;
        res         = '0;
        res_fire    = 1'b0;

        if (take)
        begin
            unique case (mode_reg)
                sitd_pkg::MODE_RECORD:
                begin
                    if (idx_reg == IDX_W'(sitd_pkg::TEMP_POS)
                        || idx_reg == IDX_W'(sitd_pkg::TEMP_POS + 1))
                        temp_next = {temp_reg[7:0], rx_byte};
                    else if (idx_reg == IDX_W'(sitd_pkg::HUMI_POS)
                             || idx_reg == IDX_W'(sitd_pkg::HUMI_POS + 1))
                        humi_next = {humi_reg[7:0], rx_byte};
                    else if (idx_reg == IDX_W'(sitd_pkg::LIGHT_POS))
                        light_next = {24'd0, rx_byte};
                    else if (idx_reg == IDX_W'(sitd_pkg::LIGHT_POS + 1))
                        light_next[15:8] = rx_byte;
                    else if (idx_reg == IDX_W'(sitd_pkg::LIGHT_POS + 2))
                        light_next[23:16] = rx_byte;
                    else if (idx_reg == IDX_W'(sitd_pkg::LIGHT_POS + 3))
                        light_next[31:24] = rx_byte;

                    if (idx_reg == IDX_W'(RECORD_BYTES - 1))
                    begin
                        res_fire          = 1'b1;
                        res.kind          = sitd_pkg::KIND_RECORD;
                        res.temperature   = temp_next;
                        res.humidity      = humi_next;
                        res.light_level   = light_next;
                        res.light_percent = sitd_pkg::light_to_percent(light_next);
                        mode_next         = sitd_pkg::MODE_IDLE;
                        idx_next          = '0;
                    end
                    else
                        idx_next = idx_inc;
                end

                sitd_pkg::MODE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_step;
                        text_next  = text_inc;
                        idx_next   = idx_inc;
                        if (idx_inc >= IDX_W'(LENGTH_DIGITS))
                        begin
                            res_fire         = 1'b1;
                            res.kind         = sitd_pkg::KIND_HEADER;
                            res.image_length = accum_step;
                            remain_next      = accum_step;
                            mode_next        = (accum_step != 24'd0) ? sitd_pkg::MODE_PAYLOAD
                                                                     : sitd_pkg::MODE_IDLE;
                            text_next        = '0;
                            idx_next         = '0;
                        end
                    end
                    else
                    begin
                        // broken header: the digits so far become text
                        idx_next = '0;
                        if (rx_byte == sitd_pkg::NEWLINE)
                        begin
                            res_fire        = 1'b1;
                            res.kind        = sitd_pkg::KIND_LINE;
                            res.line_length = text_reg;
                            text_next       = '0;
                            mode_next       = sitd_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            text_next = text_inc;
                            mode_next = sitd_pkg::MODE_TEXT;
                        end
                    end
                end

                sitd_pkg::MODE_PAYLOAD:
                begin
                    res_fire         = 1'b1;
                    res.kind         = sitd_pkg::KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    remain_next      = remain_dec;
                    if (remain_dec == 24'd0)
                    begin
                        res.payload_last = 1'b1;
                        mode_next        = sitd_pkg::MODE_IDLE;
                    end
                end

                sitd_pkg::MODE_TEXT:
                begin
                    if (rx_byte == sitd_pkg::NEWLINE)
                    begin
                        res_fire        = 1'b1;
                        res.kind        = sitd_pkg::KIND_LINE;
                        res.line_length = text_reg;
                        text_next       = '0;
                        mode_next       = sitd_pkg::MODE_IDLE;
                    end
                    else
                        text_next = text_inc;
                end

                default:
                begin
                    // idle, and any code that is not a mode
                    mode_next = sitd_pkg::MODE_IDLE;
                    if (rx_byte == sync_byte)
                    begin
                        mode_next = sitd_pkg::MODE_RECORD;
                        idx_next  = IDX_W'(1);
                    end
                    else if (is_digit)
                    begin
                        accum_next = {20'd0, digit_val};
                        text_next  = 16'd1;
                        idx_next   = IDX_W'(1);
                        if (LENGTH_DIGITS <= 1)
                        begin
                            res_fire         = 1'b1;
                            res.kind         = sitd_pkg::KIND_HEADER;
                            res.image_length = {20'd0, digit_val};
                            remain_next      = {20'd0, digit_val};
                            mode_next        = (digit_val != 4'd0) ? sitd_pkg::MODE_PAYLOAD
                                                                   : sitd_pkg::MODE_IDLE;
                            text_next        = '0;
                            idx_next         = '0;
                        end
                        else
                            mode_next = sitd_pkg::MODE_DIGITS;
                    end
                    else if (rx_byte != sitd_pkg::NEWLINE)
                    begin
                        text_next = 16'd1;
                        mode_next = sitd_pkg::MODE_TEXT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sitd_pkg::MODE_IDLE;
            idx_reg    <= '0;
            temp_reg   <= '0;
            humi_reg   <= '0;
            light_reg  <= '0;
            accum_reg  <= '0;
            remain_reg <= '0;
            text_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            idx_reg    <= idx_next;
            temp_reg   <= temp_next;
            humi_reg   <= humi_next;
            light_reg  <= light_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
            text_reg   <= text_next;
        end
    end

endmodule
`default_nettype wire

### hdl/sitd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_checker: port-level checks of the deframer
// Watches the top-level ports only; attached through bind.
// ----------------------------------------------------------------------------
module sitd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_valid,
    input wire logic        rx_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  out_kind,
    input wire logic [6:0]  light_percent,
    input wire logic        payload_last
);

    // A waiting result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("res_valid dropped while stalled");

    // An empty result slot never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("rx_ready low with empty result slot");

    // A new result needs a byte transfer on the previous edge
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid && !res_ready) |-> $past(rx_valid && rx_ready))
        else $error("result appeared without a byte transfer");

    // Last flag only on payload results; percent never above full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!payload_last || out_kind == sitd_pkg::KIND_PAYLOAD)
                      && (light_percent <= sitd_pkg::PERCENT_FULL))
        else $error("inconsistent result fields");

endmodule

bind sensor_image_text_stream_deframer_unit sitd_checker u_sitd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_kind      (out_kind),
    .light_percent (light_percent),
    .payload_last  (payload_last)
);
`default_nettype wire

### tb/sensor_image_text_stream_deframer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_image_text_stream_deframer_unit_tb: self-checking deframer bench
// Feeds byte streams of sensor records, image headers with payload, and text
// lines into the deframer. A cycle-free model of the parser predicts every
// result, and each result transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module sensor_image_text_stream_deframer_unit_tb;

    import sitd_pkg::*;

    localparam int RECORD_LEN = RECORD_BYTES_DEF;
    localparam int DIGITS_LEN = LENGTH_DIGITS_DEF;
    // bytes of random frames in each idling setting
    localparam int RANDOM_BUDGET = 380;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        sync_byte_we    = 1'b0;
    logic [7:0]  sync_byte_wdata = 8'h00;
    logic        rx_valid        = 1'b0;
    logic [7:0]  rx_byte         = 8'h00;
    logic        res_ready       = 1'b0;
    logic        rx_ready;
    logic        res_valid;
    logic [1:0]  out_kind;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [31:0] light_level;
    logic [6:0]  light_percent;
    logic [23:0] image_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [15:0] line_length;

    // Parser state as predicted from the bytes transferred so far
    logic [7:0]  sync_cfg  = SYNC_RESET;
    mode_t       pmode     = MODE_IDLE;
    logic [5:0]  pindex    = '0;
    logic [15:0] temp_acc  = '0;
    logic [15:0] humi_acc  = '0;
    logic [31:0] light_acc = '0;
    logic [23:0] hdr_len   = '0;
    logic [23:0] pay_left  = '0;
    logic [15:0] line_cnt  = '0;

    // Results predicted but not yet seen on the result port, oldest first
    result_t     results_due[$];

    int          gap_pct    = 20;
    int          stall_pct  = 61;
    int          mismatches = 0;
    int          n_bytes    = 0;
    int          n_syncs    = 0;
    int          n_kind[4]  = '{0, 0, 0, 0};

    sensor_image_text_stream_deframer_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sync_byte_we    (sync_byte_we),
        .sync_byte_wdata (sync_byte_wdata),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .out_kind        (out_kind),
        .temperature     (temperature),
        .humidity        (humidity),
        .light_level     (light_level),
        .light_percent   (light_percent),
        .image_length    (image_length),
        .payload_byte    (payload_byte),
        .payload_last    (payload_last),
        .line_length     (line_length)
    );

    always #5 clk = ~clk;

    // Stall the result side at random; stall_pct of zero keeps ready high.
    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------------

    function automatic void bump_line();
        if (line_cnt != COUNT_MAX)
            line_cnt = line_cnt + 16'd1;
    endfunction

    // Close a text line: report its length and go back to idle.
    function automatic result_t close_line();
        result_t r;
        r = '0;
        r.kind = KIND_LINE;
        r.line_length = line_cnt;
        line_cnt = '0;
        pmode = MODE_IDLE;
        return r;
    endfunction

    // Close a length header: arm the payload counter, or go idle on zero.
    function automatic result_t close_header();
        result_t r;
        r = '0;
        r.kind = KIND_HEADER;
        r.image_length = hdr_len;
        pay_left = hdr_len;
        if (hdr_len != '0)
            pmode = MODE_PAYLOAD;
        else
            pmode = MODE_IDLE;
        line_cnt = '0;
        pindex = '0;
        return r;
    endfunction

    // Advance the predicted parser by one transferred byte and queue the
    // result it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        logic    fire;
        logic    is_digit;
        r = '0;
        fire = 1'b0;
        is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        case (pmode)
            MODE_RECORD:
            begin
                if (pindex == TEMP_POS || pindex == TEMP_POS + 1)
                    temp_acc = {temp_acc[7:0], b};
                else if (pindex == HUMI_POS || pindex == HUMI_POS + 1)
                    humi_acc = {humi_acc[7:0], b};
                else if (pindex == LIGHT_POS)
                    light_acc = {24'd0, b};
                else if (pindex > LIGHT_POS && pindex <= LIGHT_POS + 3)
                    light_acc[8 * (pindex - LIGHT_POS) +: 8] = b;
                if (pindex + 1 >= RECORD_LEN)
                begin
                    r.kind = KIND_RECORD;
                    r.temperature = temp_acc;
                    r.humidity = humi_acc;
                    r.light_level = light_acc;
                    if (light_acc > LIGHT_FULL)
                        r.light_percent = PERCENT_FULL;
                    else
                        r.light_percent = 7'(light_acc / 32'd10);
                    fire = 1'b1;
                    pmode = MODE_IDLE;
                    pindex = '0;
                end
                else
                begin
                    pindex = pindex + 6'd1;
                end
            end
            MODE_DIGITS:
            begin
                if (is_digit)
                begin
                    hdr_len = hdr_len * 24'd10 + 24'(b - ASCII_ZERO);
                    bump_line();
                    pindex = pindex + 6'd1;
                    if (pindex >= DIGITS_LEN)
                    begin
                        r = close_header();
                        fire = 1'b1;
                    end
                end
                else
                begin
                    // a broken header carries on as a text line
                    pindex = '0;
                    if (b == NEWLINE)
                    begin
                        r = close_line();
                        fire = 1'b1;
                    end
                    else
                    begin
                        bump_line();
                        pmode = MODE_TEXT;
                    end
                end
            end
            MODE_PAYLOAD:
            begin
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                if (pay_left != '0)
                    pay_left = pay_left - 24'd1;
                if (pay_left == '0)
                begin
                    r.payload_last = 1'b1;
                    pmode = MODE_IDLE;
                end
                fire = 1'b1;
            end
            MODE_TEXT:
            begin
                if (b == NEWLINE)
                begin
                    r = close_line();
                    fire = 1'b1;
                end
                else
                begin
                    bump_line();
                end
            end
            default:
            begin
                // idle: the sync byte wins over digits and newline
                pmode = MODE_IDLE;
                if (b == sync_cfg)
                begin
                    pmode = MODE_RECORD;
                    pindex = 6'd1;
                end
                else if (is_digit)
                begin
                    hdr_len = 24'(b - ASCII_ZERO);
                    line_cnt = 16'd1;
                    pindex = 6'd1;
                    if (DIGITS_LEN <= 1)
                    begin
                        r = close_header();
                        fire = 1'b1;
                    end
                    else
                    begin
                        pmode = MODE_DIGITS;
                    end
                end
                else if (b != NEWLINE)
                begin
                    line_cnt = 16'd1;
                    pmode = MODE_TEXT;
                end
            end
        endcase
        if (fire)
            results_due.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_mismatch(what, want, got);
    endtask

    // Compare every result transfer against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (results_due.size() == 0)
            begin
                note_mismatch("result with nothing due, kind", 32'd0, {30'd0, out_kind});
            end
            else
            begin
                want = results_due.pop_front();
                check_field("out_kind", want.kind, out_kind);
                check_field("temperature", want.temperature, temperature);
                check_field("humidity", want.humidity, humidity);
                check_field("light_level", want.light_level, light_level);
                check_field("light_percent", want.light_percent, light_percent);
                check_field("image_length", want.image_length, image_length);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("payload_last", want.payload_last, payload_last);
                check_field("line_length", want.line_length, line_length);
                n_kind[want.kind]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at random, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        n_bytes++;
        deframe_byte(b);
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid and let every predicted result drain, plus a short settle.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        wait_idle();
        sync_byte_we    <= 1'b1;
        sync_byte_wdata <= value;
        @(posedge clk);
        sync_byte_we    <= 1'b0;
        sync_cfg = value;
        n_syncs++;
    endtask

    // Full sensor record: the sync byte, then random bytes outside the named fields.
    task automatic send_record(input logic [15:0] t, input logic [15:0] h,
                               input logic [31:0] l);
        int         pos;
        logic [7:0] b;
        send_byte(sync_cfg);
        for (pos = 1; pos < RECORD_LEN; pos++)
        begin
            if (pos == TEMP_POS)
                b = t[15:8];
            else if (pos == TEMP_POS + 1)
                b = t[7:0];
            else if (pos == HUMI_POS)
                b = h[15:8];
            else if (pos == HUMI_POS + 1)
                b = h[7:0];
            else if (pos >= LIGHT_POS && pos < LIGHT_POS + 4)
                b = l[8 * (pos - LIGHT_POS) +: 8];
            else
                b = 8'($urandom_range(255));
            send_byte(b);
        end
    endtask

    // Decimal length header followed by body random payload bytes.
    task automatic send_image(input int unsigned len, input int unsigned body);
        int unsigned div;
        int          k;
        div = 1;
        for (k = 1; k < DIGITS_LEN; k++)
            div = div * 10;
        for (k = 0; k < DIGITS_LEN; k++)
        begin
            send_byte(ASCII_ZERO + 8'((len / div) % 10));
            div = div / 10;
        end
        for (k = 0; k < body; k++)
            send_byte(8'($urandom_range(255)));
    endtask

    // Push the parser back to idle: end a line, or finish a record or image.
    task automatic drain_parser();
        while (pmode != MODE_IDLE)
        begin
            if (pmode == MODE_TEXT || pmode == MODE_DIGITS)
                send_byte(NEWLINE);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == NEWLINE)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // One frame: mostly well formed, some broken headers and raw noise.
    task automatic send_random_frame();
        int          pick;
        int          n;
        int          i;
        int unsigned len;
        logic [31:0] light;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(1) != 0)
                light = 32'($urandom_range(1100));
            else
                light = $urandom();
            send_record(16'($urandom()), 16'($urandom()), light);
        end
        else if (pick < 50)
        begin
            n = $urandom_range(99);
            if (n < 10)
                len = 0;
            else if (n < 85)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 40);
            send_image(len, len);
        end
        else if (pick < 75)
        begin
            n = $urandom_range(24);
            for (i = 0; i < n; i++)
            begin
                b = rand_text_byte();
                // keep the first byte from opening a record or a header
                while (i == 0 && (b == sync_cfg || (b >= ASCII_ZERO && b <= ASCII_NINE)))
                    b = rand_text_byte();
                send_byte(b);
            end
            send_byte(NEWLINE);
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, DIGITS_LEN - 1);
            for (i = 0; i < n; i++)
                send_byte(ASCII_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(1) != 0)
            begin
                b = 8'($urandom_range(255));
                while (b >= ASCII_ZERO && b <= ASCII_NINE)
                    b = 8'($urandom_range(255));
                send_byte(b);
                n = $urandom_range(6);
                for (i = 0; i < n; i++)
                    send_byte(rand_text_byte());
            end
            send_byte(NEWLINE);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and the light percentage around its 1000 lux knee.
    task automatic test_sensor_records();
        send_record(16'hFFFF, 16'h0000, 32'd999);
        send_record(16'h0000, 16'hFFFF, 32'd1000);
        send_record(16'h1234, 16'hABCD, 32'd1001);
        send_record(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_record(16'h8001, 16'h7FFE, 32'd0);
    endtask

    // Short images, a single-byte image and a zero length header.
    task automatic test_image_frames();
        send_image(3, 3);
        send_image(0, 0);
        send_image(1, 1);
        send_image(12, 12);
    endtask

    task automatic test_text_lines();
        // empty line in idle gives nothing
        send_byte(NEWLINE);
        // whitespace and carriage return count as line bytes
        send_str("a\t \015\n");
        // sync byte in the middle of a text line is plain text
        send_str("x");
        send_byte(sync_cfg);
        send_str("y\n");
        // broken headers turn into text lines
        send_str("12x3\n");
        send_str("42\n");
        send_str("123456\n");
        send_str("7");
        send_byte(sync_cfg);
        send_byte(NEWLINE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(NEWLINE);
    endtask

    // Sync byte as a digit, as a newline and at both ends of the byte range.
    task automatic test_sync_settings();
        write_sync(ASCII_ZERO + 8'd5);
        send_record(16'h0102, 16'h0304, 32'd555);
        send_str("15\n");
        write_sync(NEWLINE);
        send_record(16'hFEDC, 16'hBA98, 32'd12345);
        send_str("ok\n");
        write_sync(8'h00);
        send_record(16'h00FF, 16'hFF00, 32'd10);
        write_sync(8'hFF);
        send_record(16'h5A5A, 16'hA5A5, 32'd9);
    endtask

    task automatic test_random_traffic(input int gap, input int stall,
                                       input logic [7:0] sync, input int budget);
        int start;
        write_sync(sync);
        gap_pct = gap;
        stall_pct = stall;
        start = n_bytes;
        while (n_bytes - start < budget)
        begin
            // resync most of the time so frames start from idle
            if (pmode != MODE_IDLE && $urandom_range(3) != 0)
                drain_parser();
            send_random_frame();
        end
        drain_parser();
    endtask

    // Largest header; the run stops a few payload bytes into the image.
    task automatic test_open_image();
        drain_parser();
        send_image(9_999_999, 4);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sensor_records();
        test_image_frames();
        test_text_lines();
        test_sync_settings();
        test_random_traffic(20, 61, SYNC_RESET, RANDOM_BUDGET);
        test_random_traffic(61, 20, 8'($urandom_range(255)), RANDOM_BUDGET);
        test_random_traffic(0, 0, SYNC_RESET, RANDOM_BUDGET);
        test_open_image();

        wait_idle();
        repeat (5) @(posedge clk);

        $display("Sent %0d bytes under %0d sync settings, with idling on each side and none.",
                 n_bytes, n_syncs);
        $display("Checked %0d records, %0d headers, %0d payload bytes, %0d text lines.",
                 n_kind[KIND_RECORD], n_kind[KIND_HEADER], n_kind[KIND_PAYLOAD],
                 n_kind[KIND_LINE]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still due", results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sensor_image_text_stream_deframer_unit.f
hdl/sitd_pkg.sv
hdl/sitd_parser.sv
hdl/sensor_image_text_stream_deframer_unit.sv
hdl/sitd_checker.sv
tb/sensor_image_text_stream_deframer_unit_tb.sv
